>>> src/mm_pkg.sv
// Shared constants, step codes and control/status structs for the matrix multiply block.
// No dependencies; imported by every module of the block.
package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int ELEM_BITS = 16;
    localparam int IDX_W     = 3;
    localparam int DIM_W     = 4;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int PROD_W    = 2 * ELEM_BITS;
    localparam int ACC_W     = 35;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd3;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] ST_CHECK = 4'd1;
    localparam logic [STEP_W-1:0] ST_ROW   = 4'd2;
    localparam logic [STEP_W-1:0] ST_CELL  = 4'd3;
    localparam logic [STEP_W-1:0] ST_READ  = 4'd4;
    localparam logic [STEP_W-1:0] ST_MUL   = 4'd5;
    localparam logic [STEP_W-1:0] ST_ACC   = 4'd6;
    localparam logic [STEP_W-1:0] ST_EMIT  = 4'd7;
    localparam logic [STEP_W-1:0] ST_NROW  = 4'd8;
    localparam logic [STEP_W-1:0] ST_DONE  = 4'd9;
    localparam logic [STEP_W-1:0] ST_ERR   = 4'd10;

    localparam logic [2:0] COND_NEXT   = 3'd0;
    localparam logic [2:0] COND_ALWAYS = 3'd1;
    localparam logic [2:0] COND_NO_GO  = 3'd2;
    localparam logic [2:0] COND_DIMERR = 3'd3;
    localparam logic [2:0] COND_K_MORE = 3'd4;
    localparam logic [2:0] COND_J_MORE = 3'd5;
    localparam logic [2:0] COND_I_MORE = 3'd6;

    typedef struct packed {
        logic              clr_i;
        logic              inc_i;
        logic              clr_j;
        logic              inc_j;
        logic              clr_k;
        logic              inc_k;
        logic              clr_acc;
        logic              rd_en;
        logic              mul_en;
        logic              acc_en;
        logic              emit;
        logic              emit_err;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic go;
        logic dim_err;
        logic k_more;
        logic j_more;
        logic i_more;
    } stat_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (v > DIM_W'(MAX_DIM))
            begin
                r = DIM_W'(MAX_DIM);
            end
            return r;
        end
    endfunction

endpackage

>>> src/mm_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jump logic.
// Depends on mm_pkg for step codes, condition codes and the ctrl_t/stat_t structs.
module mm_seq
    import mm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  busy
);

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    logic              take;

    function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
        ctrl_t w;
        begin
            w = '0;
            case (step)
                ST_IDLE:
                begin
                    w.cond   = COND_NO_GO;
                    w.target = ST_IDLE;
                end
                ST_CHECK:
                begin
                    w.clr_i  = 1'b1;
                    w.cond   = COND_DIMERR;
                    w.target = ST_ERR;
                end
                ST_ROW:
                begin
                    w.clr_j = 1'b1;
                end
                ST_CELL:
                begin
                    w.clr_k   = 1'b1;
                    w.clr_acc = 1'b1;
                end
                ST_READ:
                begin
                    w.rd_en = 1'b1;
                end
                ST_MUL:
                begin
                    w.mul_en = 1'b1;
                end
                ST_ACC:
                begin
                    w.acc_en = 1'b1;
                    w.inc_k  = 1'b1;
                    w.cond   = COND_K_MORE;
                    w.target = ST_READ;
                end
                ST_EMIT:
                begin
                    w.emit   = 1'b1;
                    w.inc_j  = 1'b1;
                    w.cond   = COND_J_MORE;
                    w.target = ST_CELL;
                end
                ST_NROW:
                begin
                    w.inc_i  = 1'b1;
                    w.cond   = COND_I_MORE;
                    w.target = ST_ROW;
                end
                ST_DONE:
                begin
                    w.cond   = COND_ALWAYS;
                    w.target = ST_IDLE;
                end
                ST_ERR:
                begin
                    w.emit_err = 1'b1;
                    w.cond     = COND_ALWAYS;
                    w.target   = ST_IDLE;
                end
                default:
                begin
                    w.cond   = COND_ALWAYS;
                    w.target = ST_IDLE;
                end
            endcase
            return w;
        end
    endfunction

    assign ctrl = rom_word(pc_reg);
    assign busy = (pc_reg != ST_IDLE);

    always_comb
    begin
        case (ctrl.cond)
            COND_NEXT:   take = 1'b0;
            COND_ALWAYS: take = 1'b1;
            COND_NO_GO:  take = !stat.go;
            COND_DIMERR: take = stat.dim_err;
            COND_K_MORE: take = stat.k_more;
            COND_J_MORE: take = stat.j_more;
            COND_I_MORE: take = stat.i_more;
            default:     take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> src/mm_dpath.sv
// Datapath: size registers, A/B element stores, loop counters, multiply-accumulate and result regs.
// Depends on mm_pkg; driven by the control word from mm_seq.
module mm_dpath
    import mm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctrl_t                       ctrl,
    input  logic                        accept,
    input  logic [1:0]                  opcode,
    input  logic [IDX_W-1:0]            row_index,
    input  logic [IDX_W-1:0]            col_index,
    input  logic signed [ELEM_BITS-1:0] element_value,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DIM_W-1:0]            cfg_data,
    output stat_t                       stat,
    output logic                        out_valid,
    output logic [IDX_W-1:0]            out_row,
    output logic [IDX_W-1:0]            out_col,
    output logic signed [ACC_W-1:0]     product_value,
    output logic                        dim_error,
    output logic                        last
);

    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;

    logic [ELEM_BITS-1:0] a_mem [DEPTH];
    logic [ELEM_BITS-1:0] b_mem [DEPTH];
    logic [DEPTH-1:0]     a_vld_reg;
    logic [DEPTH-1:0]     b_vld_reg;

    logic [IDX_W-1:0] i_reg, j_reg, k_reg;

    logic [ELEM_BITS-1:0]     a_rd_reg, b_rd_reg;
    logic                     a_rv_reg, b_rv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg, out_col_reg;
    logic signed [ACC_W-1:0]  out_val_reg;
    logic                     out_err_reg, out_last_reg;

    logic              wr_a, wr_b;
    logic [ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;
    logic              i_last, j_last;
    logic signed [ELEM_BITS-1:0] a_op, b_op;

    assign wr_addr   = {row_index, col_index};
    assign wr_a      = accept && (opcode == OP_LOAD_A)
                       && ({1'b0, row_index} < a_rows_reg) && ({1'b0, col_index} < a_cols_reg);
    assign wr_b      = accept && (opcode == OP_LOAD_B)
                       && ({1'b0, row_index} < b_rows_reg) && ({1'b0, col_index} < b_cols_reg);
    assign a_rd_addr = {i_reg, k_reg};
    assign b_rd_addr = {k_reg, j_reg};

    assign i_last = ({1'b0, i_reg} + DIM_W'(1)) == a_rows_reg;
    assign j_last = ({1'b0, j_reg} + DIM_W'(1)) == b_cols_reg;

    assign stat.go      = accept && (opcode == OP_COMPUTE);
    assign stat.dim_err = (a_cols_reg != b_rows_reg);
    assign stat.k_more  = ({1'b0, k_reg} + DIM_W'(1)) != a_cols_reg;
    assign stat.j_more  = !j_last;
    assign stat.i_more  = !i_last;

    // Entries never written since reset read as zero.
    assign a_op = a_rv_reg ? $signed(a_rd_reg) : '0;
    assign b_op = b_rv_reg ? $signed(b_rd_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_W'(MAX_DIM);
            a_cols_reg <= DIM_W'(MAX_DIM);
            b_rows_reg <= DIM_W'(MAX_DIM);
            b_cols_reg <= DIM_W'(MAX_DIM);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_A_ROWS: a_rows_reg <= clamp_dim(cfg_data);
                REG_A_COLS: a_cols_reg <= clamp_dim(cfg_data);
                REG_B_ROWS: b_rows_reg <= clamp_dim(cfg_data);
                REG_B_COLS: b_cols_reg <= clamp_dim(cfg_data);
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= '0;
            b_vld_reg <= '0;
        end
        else
        begin
            if (wr_a)
            begin
                a_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr_b)
            begin
                b_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            a_mem[wr_addr] <= element_value;
        end
        if (ctrl.rd_en)
        begin
            a_rd_reg <= a_mem[a_rd_addr];
            a_rv_reg <= a_vld_reg[a_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            b_mem[wr_addr] <= element_value;
        end
        if (ctrl.rd_en)
        begin
            b_rd_reg <= b_mem[b_rd_addr];
            b_rv_reg <= b_vld_reg[b_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            if (ctrl.clr_i)
            begin
                i_reg <= '0;
            end
            else if (ctrl.inc_i)
            begin
                i_reg <= i_reg + IDX_W'(1);
            end
            if (ctrl.clr_j)
            begin
                j_reg <= '0;
            end
            else if (ctrl.inc_j)
            begin
                j_reg <= j_reg + IDX_W'(1);
            end
            if (ctrl.clr_k)
            begin
                k_reg <= '0;
            end
            else if (ctrl.inc_k)
            begin
                k_reg <= k_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= a_op * b_op;
        end
        if (ctrl.clr_acc)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= ctrl.emit || ctrl.emit_err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit_err)
        begin
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_val_reg  <= '0;
            out_err_reg  <= 1'b1;
            out_last_reg <= 1'b1;
        end
        else if (ctrl.emit)
        begin
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_val_reg  <= acc_reg;
            out_err_reg  <= 1'b0;
            out_last_reg <= i_last && j_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = out_val_reg;
    assign dim_error     = out_err_reg;
    assign last          = out_last_reg;

endmodule

>>> src/matrix_multiply.sv
// Top level of the fixed-point matrix multiply block: sequencer plus datapath.
// Depends on mm_pkg, mm_seq and mm_dpath.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ---------------------------------------------------
//   command   start, busy            opcode, row_index, col_index, element_value
//   result    out_valid (strobe)     out_row, out_col, product_value, dim_error, last
//   config    cfg_write              cfg_index, cfg_data
//
// A load is taken while idle; busy stays low. A compute transfer runs the three-step
// read/multiply/accumulate microcode loop over the single multiplier N times for each
// of the R*C results, for R = a_rows, C = b_cols, N = a_cols. A size mismatch returns
// one error result and busy drops after the ERR step. Reset idles the sequencer, sets
// the size registers to MAX_DIM and clears the store valid bits at once; no clearing
// pass. Each result shows for one cycle and cannot be stalled.
module matrix_multiply
    import mm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  opcode,
    input  logic [IDX_W-1:0]            row_index,
    input  logic [IDX_W-1:0]            col_index,
    input  logic signed [ELEM_BITS-1:0] element_value,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DIM_W-1:0]            cfg_data,
    output logic                        out_valid,
    output logic [IDX_W-1:0]            out_row,
    output logic [IDX_W-1:0]            out_col,
    output logic signed [ACC_W-1:0]     product_value,
    output logic                        dim_error,
    output logic                        last
);

    ctrl_t ctrl;
    stat_t stat;
    logic  accept;

    assign accept = start && !busy;

    mm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    mm_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .accept        (accept),
        .opcode        (opcode),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .dim_error     (dim_error),
        .last          (last)
    );

endmodule

>>> src/mm_checker.sv
// Port-level checker for matrix_multiply, attached by the bind below.
// Depends on mm_pkg for field widths and opcodes.
module mm_checker
    import mm_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [1:0]                  opcode,
    input logic                        out_valid,
    input logic [IDX_W-1:0]            out_row,
    input logic [IDX_W-1:0]            out_col,
    input logic signed [ACC_W-1:0]     product_value,
    input logic                        dim_error,
    input logic                        last
);

    // A compute transfer must hold the block busy on the next cycle.
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (opcode == OP_COMPUTE) |=> busy)
        else $error("compute transfer did not raise busy");

    // The error result is the only result of its run.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dim_error |-> last)
        else $error("error result without last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dim_error |-> (out_row == '0) && (out_col == '0) && (product_value == '0))
        else $error("error result carries nonzero payload");

    // Results are spaced by the accumulate loop; never two in a row.
    a_no_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid)
        else $error("results on consecutive cycles");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .out_valid     (out_valid),
    .out_row       (out_row),
    .out_col       (out_col),
    .product_value (product_value),
    .dim_error     (dim_error),
    .last          (last)
);
